// File: rtl/skse_pkg.sv
package skse_pkg;

  // matrix geometry
  localparam int MAX_VERTICES  = 8;
  localparam int FRACTION_BITS = 8;
  localparam int SLOT_COUNT    = MAX_VERTICES * MAX_VERTICES;
  localparam int IDX_W         = $clog2(SLOT_COUNT);
  localparam int VTX_W         = $clog2(MAX_VERTICES);

  // field widths
  localparam int COST_W  = 24;
  localparam int SUM_W   = COST_W + 1;
  localparam int KEY_W   = SUM_W - FRACTION_BITS + 1;
  localparam int ENTRY_W = 6;
  localparam int N_W     = 4;
  localparam int SEL_W   = 7;
  localparam int CNT_W   = 7;

  localparam logic [CNT_W-1:0] COUNT_LIMIT = CNT_W'(127);
  localparam logic [CNT_W-1:0] SLOT_LIMIT  = CNT_W'(SLOT_COUNT);

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;
  localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_SELECT_COUNT = CFG_IDX_W'(1);

  localparam logic [N_W-1:0]   VERTEX_COUNT_RST = N_W'(8);
  localparam logic [SEL_W-1:0] SELECT_COUNT_RST = '0;

  typedef struct packed {
    logic             start;
    logic [N_W-1:0]   n;
    logic [CNT_W-1:0] total;
    logic [CNT_W-1:0] k;
  } rank_cmd_t;

endpackage

// File: rtl/skse_if.sv
interface skse_in_if import skse_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic signed [COST_W-1:0] cost_a;
  logic signed [COST_W-1:0] cost_b;
  logic                     final_entry;

  modport source (output valid, output cost_a, output cost_b, output final_entry,
                  input ready);
  modport sink (input valid, input cost_a, input cost_b, input final_entry,
                output ready);
endinterface

interface skse_out_if import skse_pkg::*;;
  logic               valid;
  logic               ready;
  logic [ENTRY_W-1:0] entry_index;
  logic               selected;
  logic               size_error;
  logic               run_end;

  modport source (output valid, output entry_index, output selected,
                  output size_error, output run_end, input ready);
  modport sink (input valid, input entry_index, input selected,
                input size_error, input run_end, output ready);
endinterface

// File: rtl/skse_ram.sv
module skse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: rtl/skse_rank.sv
module skse_rank import skse_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rank_cmd_t             cmd_i,
  output logic [IDX_W-1:0]      rd_addr_o,
  input  logic [KEY_W-1:0]      rd_data_i,
  output logic                  done_o,
  output logic [SLOT_COUNT-1:0] marks_o
);

  typedef enum logic [4:0] {
    R_IDLE  = 5'b00001,
    R_FETCH = 5'b00010,
    R_WAIT  = 5'b00100,
    R_SWEEP = 5'b01000,
    R_MARK  = 5'b10000
  } rank_state_e;

  rank_state_e st_q, st_d;
  logic [IDX_W-1:0]      i_q, i_d;
  logic [VTX_W-1:0]      u_q, u_d, v_q, v_d;
  logic [CNT_W-1:0]      j_q, j_d;
  logic [IDX_W-1:0]      pend_q, pend_d;
  logic [CNT_W-1:0]      rank_q, rank_d;
  logic [KEY_W-1:0]      key_i_q, key_i_d;
  logic [N_W-1:0]        n_q, n_d;
  logic [CNT_W-1:0]      total_q, total_d;
  logic [CNT_W-1:0]      k_q, k_d;
  logic [SLOT_COUNT-1:0] mark_q, mark_d;

  logic [CNT_W-1:0]       last_cnt;
  logic [IDX_W-1:0]       last_idx;
  logic [VTX_W-1:0]       last_col;
  logic [VTX_W+N_W-1:0]   tr_full;
  logic                   hit;

  assign last_cnt = total_q - CNT_W'(1);
  assign last_idx = last_cnt[IDX_W-1:0];
  assign last_col = VTX_W'(n_q - N_W'(1));
  // mirrored entry (u,v) of the current (v,u)
  assign tr_full  = (VTX_W+N_W)'(u_q) * (VTX_W+N_W)'(n_q) + (VTX_W+N_W)'(v_q);
  // smaller key, or equal key at a lower index
  assign hit = ($signed(rd_data_i) < $signed(key_i_q)) ||
               ((rd_data_i == key_i_q) && (pend_q < i_q));

  always_comb begin
    st_d      = st_q;
    i_d       = i_q;
    u_d       = u_q;
    v_d       = v_q;
    j_d       = j_q;
    pend_d    = pend_q;
    rank_d    = rank_q;
    key_i_d   = key_i_q;
    n_d       = n_q;
    total_d   = total_q;
    k_d       = k_q;
    mark_d    = mark_q;
    rd_addr_o = j_q[IDX_W-1:0];
    done_o    = 1'b0;
    unique case (st_q)
      R_IDLE: begin
        if (cmd_i.start) begin
          n_d     = cmd_i.n;
          total_d = cmd_i.total;
          k_d     = cmd_i.k;
          i_d     = '0;
          u_d     = '0;
          v_d     = '0;
          mark_d  = '0;
          st_d    = R_FETCH;
        end
      end
      R_FETCH: begin
        rd_addr_o = i_q;
        st_d      = R_WAIT;
      end
      R_WAIT: begin
        key_i_d   = rd_data_i;
        rd_addr_o = '0;
        j_d       = CNT_W'(1);
        pend_d    = '0;
        rank_d    = '0;
        st_d      = R_SWEEP;
      end
      R_SWEEP: begin
        rank_d = rank_q + CNT_W'(hit);
        if (j_q < total_q) begin
          j_d    = j_q + CNT_W'(1);
          pend_d = j_q[IDX_W-1:0];
        end
        if (pend_q == last_idx) begin
          st_d = R_MARK;
        end
      end
      R_MARK: begin
        if (rank_q < k_q) begin
          mark_d[i_q]                = 1'b1;
          mark_d[tr_full[IDX_W-1:0]] = 1'b1;
        end
        if (i_q == last_idx) begin
          done_o = 1'b1;
          st_d   = R_IDLE;
        end else begin
          i_d  = i_q + IDX_W'(1);
          st_d = R_FETCH;
          if (u_q == last_col) begin
            u_d = '0;
            v_d = v_q + VTX_W'(1);
          end else begin
            u_d = u_q + VTX_W'(1);
          end
        end
      end
      default: st_d = R_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= R_IDLE;
      i_q     <= '0;
      u_q     <= '0;
      v_q     <= '0;
      j_q     <= '0;
      pend_q  <= '0;
      rank_q  <= '0;
      n_q     <= N_W'(1);
      total_q <= CNT_W'(1);
      k_q     <= '0;
      mark_q  <= '0;
    end else begin
      st_q    <= st_d;
      i_q     <= i_d;
      u_q     <= u_d;
      v_q     <= v_d;
      j_q     <= j_d;
      pend_q  <= pend_d;
      rank_q  <= rank_d;
      n_q     <= n_d;
      total_q <= total_d;
      k_q     <= k_d;
      mark_q  <= mark_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_i_q <= key_i_d;
  end

  assign marks_o = mark_q;

  a_sweep_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == R_SWEEP |-> CNT_W'(pend_q) < total_q)
    else $error("sweep index beyond loaded entries");

  a_rank_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == R_MARK |-> rank_q < total_q)
    else $error("rank not below entry count");

endmodule

// File: rtl/symmetric_k_smallest_edge_select.sv
// entries load back to back in the load state; after the final entry the
// rank engine compares every key with every key, one key compare per cycle
// on the single read port of the key memory, then n*n results follow at one
// per cycle while the sink is ready; a size mismatch skips ranking and goes
// straight to the results; reset clears control, counts and configuration
// (n = 8, k = 0); key memory is not cleared and needs no clearing pass
module symmetric_k_smallest_edge_select import skse_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  skse_in_if.sink               in_i,
  skse_out_if.source            out_o
);

  typedef enum logic [2:0] {
    S_LOAD = 3'b001,
    S_RANK = 3'b010,
    S_EMIT = 3'b100
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [N_W-1:0]   vertex_count_q;
  logic [SEL_W-1:0] select_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vertex_count_q <= VERTEX_COUNT_RST;
      select_count_q <= SELECT_COUNT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_VERTEX_COUNT: vertex_count_q <= cfg_data_i[N_W-1:0];
        CFG_SELECT_COUNT: select_count_q <= cfg_data_i[SEL_W-1:0];
        default: ;
      endcase
    end
  end

  // key: exact sum, truncated toward zero (bias negatives before the shift)
  localparam logic signed [SUM_W-1:0] RND = SUM_W'((1 << FRACTION_BITS) - 1);

  logic              in_fire;
  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] biased;
  logic signed [SUM_W-1:0] shifted;
  logic [KEY_W-1:0]  key;

  assign in_fire = in_i.valid && in_i.ready;
  assign sum     = SUM_W'(in_i.cost_a) + SUM_W'(in_i.cost_b);
  assign biased  = sum + (sum[SUM_W-1] ? RND : '0);
  assign shifted = biased >>> FRACTION_BITS;
  assign key     = KEY_W'(shifted);

  // run bookkeeping
  logic [CNT_W-1:0] loaded_q, loaded_d, loaded_inc;
  logic [N_W-1:0]   n_c;
  logic [CNT_W-1:0] total_c, k_c, total_q;
  logic             err_c, err_q;

  assign loaded_inc = (loaded_q < COUNT_LIMIT) ? loaded_q + CNT_W'(1) : loaded_q;

  always_comb begin
    if (vertex_count_q == '0) begin
      n_c = N_W'(1);
    end else if (vertex_count_q > N_W'(MAX_VERTICES)) begin
      n_c = N_W'(MAX_VERTICES);
    end else begin
      n_c = vertex_count_q;
    end
  end

  // widen before the product, 8 * 8 does not fit the vertex width
  assign total_c = CNT_W'(n_c) * CNT_W'(n_c);
  assign err_c   = loaded_inc != total_c;
  assign k_c     = (CNT_W'(select_count_q) > total_c) ? total_c : CNT_W'(select_count_q);

  // key memory and rank engine
  logic             ram_we;
  logic [IDX_W-1:0] rd_addr;
  logic [KEY_W-1:0] rd_data;
  rank_cmd_t        rank_cmd;
  logic             rank_done;
  logic [SLOT_COUNT-1:0] marks;

  assign ram_we = in_fire && (loaded_q < SLOT_LIMIT);

  skse_ram #(
    .WIDTH(KEY_W),
    .DEPTH(SLOT_COUNT)
  ) u_key_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(loaded_q[IDX_W-1:0]),
    .wdata_i(key),
    .raddr_i(rd_addr),
    .rdata_o(rd_data)
  );

  assign rank_cmd.start = in_fire && in_i.final_entry && !err_c;
  assign rank_cmd.n     = n_c;
  assign rank_cmd.total = total_c;
  assign rank_cmd.k     = k_c;

  skse_rank u_rank (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (rank_cmd),
    .rd_addr_o(rd_addr),
    .rd_data_i(rd_data),
    .done_o   (rank_done),
    .marks_o  (marks)
  );

  // result emission through one output register
  logic               out_valid_q;
  logic [ENTRY_W-1:0] entry_index_q;
  logic               selected_q, size_error_q, run_end_q;
  logic [IDX_W-1:0]   e_q, e_d;
  logic [CNT_W-1:0]   last_cnt;
  logic [IDX_W-1:0]   last_idx;
  logic               out_load;

  assign last_cnt = total_q - CNT_W'(1);
  assign last_idx = last_cnt[IDX_W-1:0];
  assign out_load = (state_q == S_EMIT) && (!out_valid_q || out_o.ready);

  assign in_i.ready = (state_q == S_LOAD);

  always_comb begin
    state_d  = state_q;
    loaded_d = loaded_q;
    e_d      = e_q;
    unique case (state_q)
      S_LOAD: begin
        if (in_fire) begin
          if (in_i.final_entry) begin
            loaded_d = '0;
            state_d  = err_c ? S_EMIT : S_RANK;
          end else begin
            loaded_d = loaded_inc;
          end
        end
      end
      S_RANK: begin
        if (rank_done) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_load) begin
          if (e_q == last_idx) begin
            e_d     = '0;
            state_d = S_LOAD;
          end else begin
            e_d = e_q + IDX_W'(1);
          end
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      loaded_q    <= '0;
      e_q         <= '0;
      out_valid_q <= 1'b0;
      total_q     <= CNT_W'(1);
      err_q       <= 1'b0;
    end else begin
      state_q  <= state_d;
      loaded_q <= loaded_d;
      e_q      <= e_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (in_fire && in_i.final_entry) begin
        total_q <= total_c;
        err_q   <= err_c;
      end
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      entry_index_q <= ENTRY_W'(e_q);
      selected_q    <= !err_q && marks[e_q];
      size_error_q  <= err_q;
      run_end_q     <= (e_q == last_idx);
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.entry_index = entry_index_q;
  assign out_o.selected    = selected_q;
  assign out_o.size_error  = size_error_q;
  assign out_o.run_end     = run_end_q;

  a_count_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_i.final_entry |=> loaded_q == '0)
    else $error("loaded count not cleared after final entry");

  a_error_no_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.size_error |-> !out_o.selected)
    else $error("marked entry in a size error run");

  a_index_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> CNT_W'(out_o.entry_index) < total_q)
    else $error("result index beyond matrix size");

endmodule

// File: verif/symmetric_k_smallest_edge_select_test.sv
module symmetric_k_smallest_edge_select_test;
  import skse_pkg::*;

  // run shape
  localparam int RANDOM_ENTRIES = 360;
  localparam int OVERFLOW_RUN   = 6;     // run that overfills the key store
  localparam int OVERFLOW_LEN   = 129;   // 128 + n*n at n = 1, catches a count wrap
  localparam int LONG_HOLD      = 400;   // cycles the sink refuses results
  localparam int SETTLE_CYCLES  = 8;     // non-final entries leave no result behind
  localparam int TAIL_CYCLES    = 32;
  localparam int MAX_REPORTS    = 10;

  localparam logic signed [COST_W-1:0] COST_MAX = {1'b0, {(COST_W-1){1'b1}}};
  localparam logic signed [COST_W-1:0] COST_MIN = {1'b1, {(COST_W-1){1'b0}}};

  typedef logic signed [COST_W-1:0] cost_t;

  // one expected result transfer
  typedef struct packed {
    logic [ENTRY_W-1:0] index;
    logic               selected;
    logic               size_error;
    logic               run_end;
  } mark_t;

  // one directed step: a register write or an entry transfer
  typedef struct packed {
    logic                  is_cfg;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    cost_t                 cost_a;
    cost_t                 cost_b;
    logic                  fin;
    logic                  typed;     // expected marks written out by hand
    logic                  t_err;
    logic [SLOT_COUNT-1:0] t_map;
  } row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  skse_in_if  cost_ch ();
  skse_out_if mark_ch ();

  symmetric_k_smallest_edge_select DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (cost_ch),
    .out_o      (mark_ch)
  );

  always #10 clk_i = ~clk_i;

  // shadow of the block: keys, load count and the two registers
  int                key_mem [SLOT_COUNT];
  int                entries_loaded;
  logic [N_W-1:0]    vtx_reg;
  logic [SEL_W-1:0]  pick_reg;
  mark_t             expected_marks [$];

  int   mismatches;
  int   holds_wanted;
  int   holds_done;
  logic steady;       // both sides run without gaps while set

  // vertex count as the block uses it: 0 counts as 1, large values clamp
  function automatic int span();
    if (vtx_reg == 0) return 1;
    if (int'(vtx_reg) > MAX_VERTICES) return MAX_VERTICES;
    return int'(vtx_reg);
  endfunction

  // store the key of one accepted entry; on the final entry rank all keys if the
  // count matches, mark the k smallest both ways round and queue one result per entry
  function automatic void load_and_rank(cost_t a, cost_t b, logic fin, logic typed,
                                        logic t_err, logic [SLOT_COUNT-1:0] t_map);
    int                    n, total, k, rank;
    logic                  err;
    logic [SLOT_COUNT-1:0] marks;
    mark_t                 m;
    // integer division truncates toward zero, as the key does
    if (entries_loaded < SLOT_COUNT)
      key_mem[entries_loaded] = (int'(a) + int'(b)) / (1 << FRACTION_BITS);
    if (entries_loaded < int'(COUNT_LIMIT))
      entries_loaded++;
    if (!fin) return;
    n     = span();
    total = n * n;
    k     = int'(pick_reg) > total ? total : int'(pick_reg);
    err   = entries_loaded != total;
    marks = '0;
    if (!err) begin
      for (int i = 0; i < total; i++) begin
        rank = 0;
        for (int j = 0; j < total; j++)
          if (key_mem[j] < key_mem[i] || (key_mem[j] == key_mem[i] && j < i))
            rank++;
        if (rank < k) begin
          marks[(i / n) * n + (i % n)] = 1'b1;
          marks[(i % n) * n + (i / n)] = 1'b1;
        end
      end
    end
    if (typed) begin
      err   = t_err;
      marks = t_map;
    end
    for (int i = 0; i < total; i++) begin
      m.index      = ENTRY_W'(i);
      m.selected   = err ? 1'b0 : marks[i];
      m.size_error = err;
      m.run_end    = (i == total - 1);
      expected_marks.push_back(m);
    end
    entries_loaded = 0;
  endfunction

  // mostly no gap, sometimes a few cycles, rarely a long one
  function automatic int idle_len();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // full-range costs, small costs that give many equal keys, or a mix
  function automatic cost_t draw_cost(int mode);
    if (mode == 0 || (mode == 2 && $urandom_range(0, 1) == 0))
      return cost_t'($urandom());
    return cost_t'(int'($urandom_range(0, 1200)) - 600);
  endfunction

  function automatic row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    row_t r;
    r         = '0;
    r.is_cfg  = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  function automatic row_t cost_row(cost_t a, cost_t b, logic fin);
    row_t r;
    r        = '0;
    r.cost_a = a;
    r.cost_b = b;
    r.fin    = fin;
    return r;
  endfunction

  // final entry whose marks can be read off directly
  function automatic row_t known_row(cost_t a, cost_t b, logic err,
                                     logic [SLOT_COUNT-1:0] map);
    row_t r;
    r        = cost_row(a, b, 1'b1);
    r.typed  = 1'b1;
    r.t_err  = err;
    r.t_map  = map;
    return r;
  endfunction

  // one entry transfer: optional gap, then hold valid until ready
  task automatic offer_entry(cost_t a, cost_t b, logic fin, logic typed,
                             logic t_err, logic [SLOT_COUNT-1:0] t_map);
    int idle;
    idle = idle_len();
    @(negedge clk_i);
    if (idle > 0) begin
      cost_ch.valid <= 1'b0;
      repeat (idle) @(negedge clk_i);
    end
    cost_ch.valid       <= 1'b1;
    cost_ch.cost_a      <= a;
    cost_ch.cost_b      <= b;
    cost_ch.final_entry <= fin;
    @(posedge clk_i);
    while (!cost_ch.ready) @(posedge clk_i);
    load_and_rank(a, b, fin, typed, t_err, t_map);
  endtask

  // stop offering and wait until every queued result has been seen
  task automatic drain_block();
    @(negedge clk_i);
    cost_ch.valid <= 1'b0;
    while (expected_marks.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // register write, only called with the block idle
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_VERTEX_COUNT) vtx_reg = val[N_W-1:0];
    else                         pick_reg = val[SEL_W-1:0];
  endtask

  // result side: compare each transfer with the oldest expectation
  always @(posedge clk_i) begin : check_marks
    mark_t want, got;
    if (rst_ni && mark_ch.valid && mark_ch.ready) begin
      got = '{mark_ch.entry_index, mark_ch.selected, mark_ch.size_error, mark_ch.run_end};
      if (expected_marks.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: entry %0d sel %0b err %0b end %0b",
                   got.index, got.selected, got.size_error, got.run_end);
      end else begin
        want = expected_marks.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("result mismatch: entry %0d/%0d sel %0b/%0b err %0b/%0b end %0b/%0b (exp/got)",
                     want.index, got.index, want.selected, got.selected,
                     want.size_error, got.size_error, want.run_end, got.run_end);
        end
      end
    end
  end

  // result side pacing: one ready cycle, then a random gap, often none; long holds on request
  initial begin : pace_results
    int hold;
    hold          = 0;
    mark_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (holds_done != holds_wanted) begin
        holds_done++;
        hold = LONG_HOLD;
      end
      if (hold > 0) begin
        mark_ch.ready <= 1'b0;
        hold--;
      end else begin
        mark_ch.ready <= 1'b1;
        hold = idle_len();
      end
    end
  end

  initial begin : stimulus
    row_t                  script [$];
    int                    random_entries, run, n, total, len, mode, r;
    logic                  hold_run, back_to_back;
    logic [CFG_DATA_W-1:0] vdata, sdata;

    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_idx_i           = CFG_VERTEX_COUNT;
    cfg_data_i          = '0;
    cost_ch.valid       = 1'b0;
    cost_ch.cost_a      = '0;
    cost_ch.cost_b      = '0;
    cost_ch.final_entry = 1'b0;
    steady              = 1'b0;
    mismatches          = 0;
    holds_wanted        = 0;
    holds_done          = 0;
    entries_loaded      = 0;
    vtx_reg             = VERTEX_COUNT_RST;
    pick_reg            = SELECT_COUNT_RST;
    foreach (key_mem[i]) key_mem[i] = 0;

    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    script = '{
      // reset config is n = 8: a lone final entry is a size error on all 64
      known_row(0, 0, 1'b1, '0),
      // extremes of both costs and truncation toward zero, n = 2, k = 2
      cfg_row(CFG_VERTEX_COUNT, 2),
      cfg_row(CFG_SELECT_COUNT, 2),
      cost_row(COST_MAX, COST_MAX, 1'b0),
      cost_row(COST_MIN, COST_MIN, 1'b0),
      cost_row(-1, 0, 1'b0),
      known_row(-257, 0, 1'b0, 64'hE),
      // vertex count 0 acts as 1, select count saturates
      cfg_row(CFG_VERTEX_COUNT, 0),
      cfg_row(CFG_SELECT_COUNT, 127),
      known_row(5, -9, 1'b0, 64'h1),
      // one entry too many
      cost_row(0, 0, 1'b0),
      known_row(0, 0, 1'b1, '0),
      // vertex count above the maximum clamps to 8, too few entries
      cfg_row(CFG_VERTEX_COUNT, 15),
      cfg_row(CFG_SELECT_COUNT, 0),
      cost_row(COST_MAX, COST_MIN, 1'b0),
      cost_row(0, 1, 1'b0),
      known_row(7, 7, 1'b1, '0),
      // four equal keys: lowest index wins
      cfg_row(CFG_VERTEX_COUNT, 2),
      cfg_row(CFG_SELECT_COUNT, 1),
      cost_row(256, 0, 1'b0),
      cost_row(0, 256, 1'b0),
      cost_row(511, -200, 1'b0),
      known_row(-1, 300, 1'b0, 64'h1),
      // off-diagonal pick mirrors across, tie on the smallest key
      cfg_row(CFG_VERTEX_COUNT, 3),
      cost_row(COST_MAX, 0, 1'b0),
      cost_row(1000, 1000, 1'b0),
      cost_row(-300, 300, 1'b0),
      cost_row(0, 0, 1'b0),
      cost_row(600, -1, 1'b0),
      cost_row(-5000, 0, 1'b0),
      cost_row(2, 2, 1'b0),
      cost_row(-4900, -100, 1'b0),
      cost_row(COST_MIN, COST_MAX, 1'b1),
      // nothing selected
      cfg_row(CFG_VERTEX_COUNT, 1),
      cfg_row(CFG_SELECT_COUNT, 0),
      known_row(100, 100, 1'b0, '0)
    };

    foreach (script[i]) begin
      if (script[i].is_cfg) begin
        drain_block();
        write_reg(script[i].reg_idx, script[i].reg_val);
      end else begin
        offer_entry(script[i].cost_a, script[i].cost_b, script[i].fin,
                    script[i].typed, script[i].t_err, script[i].t_map);
      end
    end

    // random runs: mostly exact n*n loads, some short or long ones
    random_entries = 0;
    run            = 0;
    back_to_back   = 1'b0;
    while (random_entries < RANDOM_ENTRIES) begin
      steady = ($urandom_range(0, 5) == 0);
      if (run == OVERFLOW_RUN) begin
        // more entries than the count can hold; a wrapped count would match n*n
        drain_block();
        write_reg(CFG_VERTEX_COUNT, 1);
        for (int i = 0; i < OVERFLOW_LEN; i++)
          offer_entry(draw_cost(0), draw_cost(0), i == OVERFLOW_LEN - 1, 1'b0, 1'b0, '0);
        random_entries += OVERFLOW_LEN;
      end else begin
        if (!back_to_back && (run == 0 || $urandom_range(0, 9) < 4)) begin
          drain_block();
          // small matrices mostly, the full 8 by 8 only now and then
          r = $urandom_range(0, 99);
          if (r < 50)      n = $urandom_range(1, 3);
          else if (r < 85) n = $urandom_range(4, 5);
          else if (r < 95) n = $urandom_range(6, 7);
          else             n = MAX_VERTICES;
          vdata = CFG_DATA_W'(n);
          if (n == 1 && $urandom_range(0, 2) == 0)
            vdata = '0;
          else if (n == MAX_VERTICES && $urandom_range(0, 1) == 0)
            vdata = CFG_DATA_W'($urandom_range(MAX_VERTICES + 1, 15));
          else if ($urandom_range(0, 5) == 0)
            vdata = CFG_DATA_W'(n + 16 * $urandom_range(1, 7));   // upper bits dropped
          total = n * n;
          r = $urandom_range(0, 99);
          if (r < 20)      sdata = '0;
          else if (r < 35) sdata = CFG_DATA_W'(total);
          else if (r < 50) sdata = CFG_DATA_W'($urandom_range(total, 127));
          else             sdata = CFG_DATA_W'($urandom_range(0, total));
          write_reg(CFG_VERTEX_COUNT, vdata);
          write_reg(CFG_SELECT_COUNT, sdata);
        end
        n     = span();
        total = n * n;
        len   = total;
        if ($urandom_range(0, 99) >= 82) begin
          // broken load: a few entries off in either direction
          if ($urandom_range(0, 1) == 0 && total > 3) len = total - $urandom_range(1, 3);
          else                                        len = total + $urandom_range(1, 3);
        end
        mode     = $urandom_range(0, 2);
        hold_run = (run == 3 || run == 11);
        for (int i = 0; i < len; i++) begin
          // sink stalls for a long stretch while the next run is offered
          if (hold_run && i == len - 1) holds_wanted++;
          offer_entry(draw_cost(mode), draw_cost(mode), i == len - 1, 1'b0, 1'b0, '0);
        end
        back_to_back    = hold_run;
        random_entries += len;
      end
      run++;
    end

    steady = 1'b0;
    drain_block();
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (mismatches == 0 && expected_marks.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // hard limit on the whole run
  initial begin : watchdog
    #(20 * 1000000);
    $display("simulation failed");
    $finish;
  end

endmodule

// File: symmetric_k_smallest_edge_select.f
rtl/skse_pkg.sv
rtl/skse_if.sv
rtl/skse_ram.sv
rtl/skse_rank.sv
rtl/symmetric_k_smallest_edge_select.sv
verif/symmetric_k_smallest_edge_select_test.sv
